// ----- rtl/nms_pkg.sv -----
package nms_pkg;

    localparam int MAX_BOXES = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int COORD_W   = 16;
    localparam int SCORE_W   = 16;
    localparam int SIDE_W    = COORD_W + 1;
    localparam int AREA_W    = 2 * SIDE_W - 1;
    localparam int UNI_W     = AREA_W + 1;
    localparam int THR_W     = 17;
    localparam int HALF_W    = UNI_W / 2;
    localparam int PROD_W    = THR_W + HALF_W;
    localparam int RHS_W     = PROD_W + HALF_W;
    localparam int LHS_W     = AREA_W + 16;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

    typedef struct packed {
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] top_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] bottom_y;
    } box_t;

    typedef struct packed {
        box_t                box;
        logic [SCORE_W-1:0]  score;
        logic [AREA_W-1:0]   area;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        entry_t            data;
    } mem_wr_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              overflow;
    } job_t;

    typedef struct packed {
        logic                valid;
        logic                final_box;
        logic                overflowed;
        box_t                box;
        logic [SCORE_W-1:0]  score;
    } result_t;

    // inclusive side length, zero when the edges are inverted
    function automatic logic [SIDE_W-1:0] side_len(
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi
    );
        logic signed [COORD_W+1:0] d;
        d = {{2{hi[COORD_W-1]}}, hi} - {{2{lo[COORD_W-1]}}, lo} + (COORD_W+2)'(1);
        return (d > 0) ? d[SIDE_W-1:0] : '0;
    endfunction

endpackage

// ----- rtl/box_non_maximum_suppression.sv -----
// greedy box non-maximum suppression
// input: a box is transferred at a clock edge where start is high and busy is low.
//   boxes load one per cycle while busy is low; set_end marks a set's last box.
//   up to 64 boxes are stored; later ones are dropped and overflowed is set.
// after set_end, busy stays high while the set is worked on. each pass scans
//   every stored box through a 6-stage overlap pipeline: it drops boxes that
//   overlap the current pick and finds the next best survivor at once.
// passes: one pass per kept box plus one initial pass, all through the single
//   shared scan pipe; no box of the next set is accepted until busy falls.
// output: each kept box appears for one cycle with result_valid, best first;
//   final_box marks the last one. the receiver cannot stall the block.
// cfg_write loads iou_threshold from cfg_data; write it only while idle.
// reset clears the load count, the overflow flag, the job queue and the
//   threshold (to one half); box memory contents are not cleared.
module box_non_maximum_suppression (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cfg_write,
    input  logic [nms_pkg::THR_W-1:0]          cfg_data,
    input  logic signed [nms_pkg::COORD_W-1:0] left_x,
    input  logic signed [nms_pkg::COORD_W-1:0] top_y,
    input  logic signed [nms_pkg::COORD_W-1:0] right_x,
    input  logic signed [nms_pkg::COORD_W-1:0] bottom_y,
    input  logic [nms_pkg::SCORE_W-1:0]        confidence,
    input  logic                               set_end,
    output logic                               result_valid,
    output logic signed [nms_pkg::COORD_W-1:0] kept_left_x,
    output logic signed [nms_pkg::COORD_W-1:0] kept_top_y,
    output logic signed [nms_pkg::COORD_W-1:0] kept_right_x,
    output logic signed [nms_pkg::COORD_W-1:0] kept_bottom_y,
    output logic [nms_pkg::SCORE_W-1:0]        kept_confidence,
    output logic                               final_box,
    output logic                               overflowed
);
    import nms_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             accept;
    logic             back_busy;
    logic             job_valid;
    logic             job_pop;
    box_t             in_box;
    mem_wr_t          wr;
    job_t             job;
    result_t          result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_write)
            thr_reg <= cfg_data;
    end

    assign busy   = back_busy || job_valid;
    assign accept = start && !busy;

    always_comb
    begin
        in_box.left_x   = left_x;
        in_box.top_y    = top_y;
        in_box.right_x  = right_x;
        in_box.bottom_y = bottom_y;
    end

    nms_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .box       (in_box),
        .score     (confidence),
        .set_end   (set_end),
        .job_pop   (job_pop),
        .wr        (wr),
        .job       (job),
        .job_valid (job_valid)
    );

    nms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .job       (job),
        .job_valid (job_valid),
        .thr       (thr_reg),
        .job_pop   (job_pop),
        .busy      (back_busy),
        .result    (result)
    );

    assign result_valid    = result.valid;
    assign kept_left_x     = result.box.left_x;
    assign kept_top_y      = result.box.top_y;
    assign kept_right_x    = result.box.right_x;
    assign kept_bottom_y   = result.box.bottom_y;
    assign kept_confidence = result.score;
    assign final_box       = result.final_box;
    assign overflowed      = result.overflowed;

endmodule

// ----- rtl/nms_front.sv -----
module nms_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  nms_pkg::box_t                 box,
    input  logic [nms_pkg::SCORE_W-1:0]   score,
    input  logic                          set_end,
    input  logic                          job_pop,
    output nms_pkg::mem_wr_t              wr,
    output nms_pkg::job_t                 job,
    output logic                          job_valid
);
    import nms_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             job_valid_reg;
    job_t             job_reg;
    logic             room;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;

    assign room = (count_reg < CNT_W'(MAX_BOXES));
    assign w    = side_len(box.left_x, box.right_x);
    assign h    = side_len(box.top_y, box.bottom_y);

    always_comb
    begin
        wr.en            = accept && room;
        wr.addr          = count_reg[IDX_W-1:0];
        wr.data.box      = box;
        wr.data.score    = score;
        wr.data.area     = {{(AREA_W-SIDE_W){1'b0}}, w} * {{(AREA_W-SIDE_W){1'b0}}, h};
        count_next       = room ? count_reg + CNT_W'(1) : count_reg;
        ovf_next         = ovf_reg || !room;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
            job_reg       <= '0;
        end
        else
        begin
            if (job_pop)
                job_valid_reg <= 1'b0;
            if (accept)
            begin
                if (set_end)
                begin
                    job_reg.count    <= count_next;
                    job_reg.overflow <= ovf_next;
                    job_valid_reg    <= 1'b1;
                    count_reg        <= '0;
                    ovf_reg          <= 1'b0;
                end
                else
                begin
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    assign job       = job_reg;
    assign job_valid = job_valid_reg;

endmodule

// ----- rtl/nms_back.sv -----
module nms_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  nms_pkg::mem_wr_t             wr,
    input  nms_pkg::job_t                job,
    input  logic                         job_valid,
    input  logic [nms_pkg::THR_W-1:0]    thr,
    output logic                         job_pop,
    output logic                         busy,
    output nms_pkg::result_t             result
);
    import nms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_NEXT = 4'b1000
    } state_t;

    entry_t mem [MAX_BOXES];

    state_t              state_reg;
    logic [CNT_W-1:0]    n_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic [MAX_BOXES-1:0] alive_reg;
    logic                have_pick_reg;
    logic                found_reg;
    logic                ovf_reg;
    entry_t              pick_reg;
    entry_t              best_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                res_valid_reg;
    logic                res_final_reg;
    logic                res_ovf_reg;
    entry_t              res_reg;

    // pipeline: 1 read, 2 overlap sides, 3 intersection, 4 union, 5/6 threshold products
    logic [6:1]          v_reg;
    entry_t              e_reg   [6:1];
    logic [IDX_W-1:0]    idx_reg [6:1];
    logic [SIDE_W-1:0]   iw2_reg, ih2_reg;
    logic [AREA_W-1:0]   inter_reg [6:3];
    logic [UNI_W-1:0]    uni_reg   [6:4];
    logic [PROD_W-1:0]   plo_reg   [6:5];
    logic [PROD_W-1:0]   phi6_reg;

    logic signed [COORD_W-1:0] ix_lo, ix_hi, iy_lo, iy_hi;
    logic [RHS_W-1:0]    rhs;
    logic [RHS_W-1:0]    lhs;
    logic                sup6;
    logic                issue;
    logic                pipe_busy;

    assign issue     = (state_reg == S_SCAN);
    assign pipe_busy = |v_reg;
    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign busy      = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
    end

    always_comb
    begin
        ix_lo = (pick_reg.box.left_x > e_reg[1].box.left_x) ?
                pick_reg.box.left_x : e_reg[1].box.left_x;
        ix_hi = (pick_reg.box.right_x < e_reg[1].box.right_x) ?
                pick_reg.box.right_x : e_reg[1].box.right_x;
        iy_lo = (pick_reg.box.top_y > e_reg[1].box.top_y) ?
                pick_reg.box.top_y : e_reg[1].box.top_y;
        iy_hi = (pick_reg.box.bottom_y < e_reg[1].box.bottom_y) ?
                pick_reg.box.bottom_y : e_reg[1].box.bottom_y;
        rhs   = {phi6_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, plo_reg[6]};
        lhs   = {{(RHS_W-LHS_W){1'b0}}, inter_reg[6], 16'b0};
        sup6  = have_pick_reg && (uni_reg[6] != '0) && (lhs > rhs);
    end

    // payload path
    always_ff @(posedge clk)
    begin
        e_reg[1]     <= mem[scan_reg[IDX_W-1:0]];
        idx_reg[1]   <= scan_reg[IDX_W-1:0];
        iw2_reg      <= side_len(ix_lo, ix_hi);
        ih2_reg      <= side_len(iy_lo, iy_hi);
        for (int s = 2; s <= 6; s++)
        begin
            e_reg[s]   <= e_reg[s-1];
            idx_reg[s] <= idx_reg[s-1];
        end
        inter_reg[3] <= {{(AREA_W-SIDE_W){1'b0}}, iw2_reg} *
                        {{(AREA_W-SIDE_W){1'b0}}, ih2_reg};
        inter_reg[4] <= inter_reg[3];
        inter_reg[5] <= inter_reg[4];
        inter_reg[6] <= inter_reg[5];
        uni_reg[4]   <= {1'b0, pick_reg.area} + {1'b0, e_reg[3].area} - {1'b0, inter_reg[3]};
        uni_reg[5]   <= uni_reg[4];
        uni_reg[6]   <= uni_reg[5];
        plo_reg[5]   <= {{HALF_W{1'b0}}, thr} * {{THR_W{1'b0}}, uni_reg[4][HALF_W-1:0]};
        plo_reg[6]   <= plo_reg[5];
        phi6_reg     <= {{HALF_W{1'b0}}, thr} * {{THR_W{1'b0}}, uni_reg[5][UNI_W-1:HALF_W]};
        if (state_reg == S_NEXT && have_pick_reg)
            res_reg <= pick_reg;
        if (state_reg == S_NEXT && found_reg)
            pick_reg <= best_reg;
        if (v_reg[6] && !sup6 && (!found_reg || e_reg[6].score > best_reg.score))
        begin
            best_reg     <= e_reg[6];
            best_idx_reg <= idx_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            scan_reg      <= '0;
            alive_reg     <= '0;
            have_pick_reg <= 1'b0;
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            v_reg         <= '0;
            res_valid_reg <= 1'b0;
            res_final_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
        end
        else
        begin
            v_reg[1]      <= issue && alive_reg[scan_reg[IDX_W-1:0]];
            v_reg[6:2]    <= v_reg[5:1];
            res_valid_reg <= 1'b0;
            if (v_reg[6])
            begin
                if (sup6)
                    alive_reg[idx_reg[6]] <= 1'b0;
                else if (!found_reg || e_reg[6].score > best_reg.score)
                    found_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        for (int i = 0; i < MAX_BOXES; i++)
                            alive_reg[i] <= (CNT_W'(i) < job.count);
                        n_reg         <= job.count;
                        ovf_reg       <= job.overflow;
                        have_pick_reg <= 1'b0;
                        found_reg     <= 1'b0;
                        scan_reg      <= '0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg == n_reg - CNT_W'(1))
                        state_reg <= S_WAIT;
                    else
                        scan_reg <= scan_reg + CNT_W'(1);
                end
                S_WAIT:
                begin
                    if (!pipe_busy)
                        state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    // the previous pick goes out once we know whether another follows
                    if (have_pick_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        res_final_reg <= !found_reg;
                        res_ovf_reg   <= ovf_reg;
                    end
                    if (found_reg)
                    begin
                        alive_reg[best_idx_reg] <= 1'b0;
                        have_pick_reg <= 1'b1;
                        found_reg     <= 1'b0;
                        scan_reg      <= '0;
                        state_reg     <= S_SCAN;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        result.valid      = res_valid_reg;
        result.final_box  = res_final_reg;
        result.overflowed = res_ovf_reg;
        result.box        = res_reg.box;
        result.score      = res_reg.score;
    end

endmodule

// ----- rtl/nms_checker.sv -----
module nms_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic set_end,
    input  logic result_valid,
    input  logic final_box
);

    // the end of a set always starts work
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && set_end) |=> busy)
        else $error("busy not raised after set end");

    // busy only rises from a transfer
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transfer");

    // nothing follows the last kept box right away
    a_final_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_box) |=> !result_valid)
        else $error("result right after final box");

endmodule

bind box_non_maximum_suppression nms_checker u_nms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .set_end      (set_end),
    .result_valid (result_valid),
    .final_box    (final_box)
);
